### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the CSV parser RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expression does not hold");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/cfpn_pkg.sv
// ---------------------------------------------------------------------------
// cfpn_pkg
// Types and constants shared by the CSV field parser and normalizer.
// ---------------------------------------------------------------------------
package cfpn_pkg;

    localparam logic [7:0] QUOTE_CH = 8'h22;
    localparam logic [7:0] CR_CH    = 8'h0D;
    localparam logic [7:0] LF_CH    = 8'h0A;
    localparam logic [7:0] SPACE_CH = 8'h20;

    localparam logic [7:0] SEP_RESET = 8'd44;

    // queue between parser front and output back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_FIELD   = 2'd1,
        KIND_ROW     = 2'd2,
        KIND_DISCARD = 2'd3
    } t_kind;

    typedef enum logic {
        FUNC_DATA = 1'b0,
        FUNC_EOS  = 1'b1
    } t_func;

    typedef enum logic {
        REG_SEP  = 1'b0,
        REG_NORM = 1'b1
    } t_reg;

    // one queued entry: an optional held space, then the main word
    typedef struct packed {
        logic       space;
        t_kind      kind;
        logic [7:0] data;
    } t_entry;

endpackage

### src/cfpn_front.sv
// ---------------------------------------------------------------------------
// cfpn_front
// Parser state machine: takes one byte per cycle while i_accept is high and
// classifies it into at most one queue entry.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfpn_front import cfpn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_func,
    input  logic [7:0] i_in_byte,
    input  logic [7:0] i_sep,
    input  logic       i_norm,
    output logic       o_push,
    output t_entry     o_entry
);

    logic r_quoted, n_quoted;
    logic r_qseen, n_qseen;
    logic r_swallow, n_swallow;
    logic r_lrs, n_lrs;
    logic r_held, n_held;
    logic r_row, n_row;

    logic       res_valid;
    logic       done;
    logic       do_emit;
    logic [7:0] ec;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    always_comb begin
        n_quoted  = r_quoted;
        n_qseen   = r_qseen;
        n_swallow = r_swallow;
        n_lrs     = r_lrs;
        n_held    = r_held;
        n_row     = r_row;
        res_valid     = 1'b0;
        o_entry.space = 1'b0;
        o_entry.kind  = KIND_CHAR;
        o_entry.data  = 8'h00;
        done    = 1'b0;
        do_emit = 1'b0;
        ec      = i_in_byte;

        if (i_func == FUNC_EOS) begin
            if (r_row) begin
                res_valid    = 1'b1;
                o_entry.kind = KIND_DISCARD;
            end
            n_quoted  = 1'b0;
            n_qseen   = 1'b0;
            n_swallow = 1'b0;
            n_row     = 1'b0;
            n_lrs     = 1'b1;
            n_held    = 1'b0;
        end else begin
            if (r_swallow) begin
                n_swallow = 1'b0;
                if (i_in_byte == LF_CH) begin
                    done = 1'b1;
                end
            end
            // resolve the pending quote: doubled gives a literal, else close
            if (!done && r_qseen) begin
                n_qseen = 1'b0;
                if (i_in_byte == QUOTE_CH) begin
                    n_row   = 1'b1;
                    do_emit = 1'b1;
                    ec      = QUOTE_CH;
                    done    = 1'b1;
                end else begin
                    n_quoted = 1'b0;
                end
            end
            if (!done) begin
                if (i_in_byte == QUOTE_CH) begin
                    if (!n_quoted) begin
                        n_quoted = 1'b1;
                    end else begin
                        n_qseen = 1'b1;
                    end
                    n_row = 1'b1;
                end else if (!n_quoted && i_in_byte == i_sep) begin
                    res_valid    = 1'b1;
                    o_entry.kind = KIND_FIELD;
                    n_lrs  = 1'b1;
                    n_held = 1'b0;
                    n_row  = 1'b1;
                end else if (!n_quoted && (i_in_byte == CR_CH || i_in_byte == LF_CH)) begin
                    res_valid    = 1'b1;
                    o_entry.kind = KIND_ROW;
                    n_lrs     = 1'b1;
                    n_held    = 1'b0;
                    n_swallow = 1'b1;
                    n_row     = 1'b0;
                end else begin
                    n_row   = 1'b1;
                    do_emit = 1'b1;
                end
            end

            if (do_emit) begin
                if (i_norm) begin
                    if (ec == SPACE_CH) begin
                        // hold the space until a kept character follows
                        if (!r_lrs) begin
                            n_held = 1'b1;
                            n_lrs  = 1'b1;
                        end
                    end else begin
                        res_valid     = 1'b1;
                        o_entry.space = r_held;
                        o_entry.data  = to_lower(ec);
                        n_held = 1'b0;
                        n_lrs  = 1'b0;
                    end
                end else begin
                    res_valid     = 1'b1;
                    o_entry.space = r_held;
                    o_entry.data  = ec;
                    n_held = 1'b0;
                    n_lrs  = (ec == SPACE_CH);
                end
            end
        end
    end

    assign o_push = i_accept && res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoted  <= 1'b0;
            r_qseen   <= 1'b0;
            r_swallow <= 1'b0;
            r_lrs     <= 1'b1;
            r_held    <= 1'b0;
            r_row     <= 1'b0;
        end else if (i_accept) begin
            r_quoted  <= n_quoted;
            r_qseen   <= n_qseen;
            r_swallow <= n_swallow;
            r_lrs     <= n_lrs;
            r_held    <= n_held;
            r_row     <= n_row;
        end
    end

    `ASSERT_IMPLIES(a_held_implies_lrs, i_clk, i_rst_n, r_held, r_lrs)
    `ASSERT_IMPLIES(a_qseen_implies_quoted, i_clk, i_rst_n, r_qseen, r_quoted)
    `ASSERT_NEXT(a_eos_clears_row, i_clk, i_rst_n, i_accept && i_func == FUNC_EOS,
                 !r_row && !r_quoted && !r_held)

endmodule

### src/cfpn_queue.sv
// ---------------------------------------------------------------------------
// cfpn_queue
// Small register FIFO that decouples the parser from the output stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfpn_queue import cfpn_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, r_count <= (QAW+1)'(QDEPTH))
    `ASSERT_ALWAYS(a_no_push_full, i_clk, i_rst_n, !(i_push && o_full))
    `ASSERT_ALWAYS(a_no_pop_empty, i_clk, i_rst_n, !(i_pop && !o_valid))

endmodule

### src/cfpn_back.sv
// ---------------------------------------------------------------------------
// cfpn_back
// Output stage: expands each queued entry into one or two words and holds
// them in an output register until taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfpn_back import cfpn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_entry     i_q_entry,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic       r_valid;
    logic       r_phase;
    t_kind      r_kind;
    logic [7:0] r_byte;
    logic       r_last;

    logic load;
    logic send_space;

    assign load       = !r_valid || i_ready;
    assign send_space = i_q_entry.space && !r_phase;
    assign o_q_pop    = load && i_q_valid && !send_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_phase <= send_space;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            if (send_space) begin
                // emit the held space ahead of its character
                r_kind <= KIND_CHAR;
                r_byte <= SPACE_CH;
                r_last <= 1'b0;
            end else begin
                r_kind <= i_q_entry.kind;
                r_byte <= i_q_entry.data;
                r_last <= 1'b1;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_out_kind = r_kind;
    assign o_out_byte = r_byte;
    assign o_out_last = r_last;

    `ASSERT_IMPLIES(a_phase_mid_item, i_clk, i_rst_n, r_phase, r_valid && !r_last)
    `ASSERT_NEXT(a_pop_gives_last, i_clk, i_rst_n, o_q_pop, r_valid && r_last)
    `ASSERT_NEXT(a_stall_keeps_word, i_clk, i_rst_n, r_valid && !i_ready, r_valid)

endmodule

### src/csv_field_parser_normalizer_top.sv
// ---------------------------------------------------------------------------
// csv_field_parser_normalizer_top
// CSV byte stream parser with optional whitespace and case normalization.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one word per byte: i_func selects
//   a text byte or end of stream, i_in_byte holds the byte. Output channel
//   (o_valid/i_ready) carries result words: field characters, end of field,
//   end of row or discard of a partial row, with o_out_last marking the
//   final word caused by one input word.
//   Throughput: one input word per cycle while o_ready is high. An input
//   word yields zero, one or two result words; the output register drains
//   one word per cycle while i_ready is high, so a word that carries a held
//   space goes out as two result words. A result word passes through the
//   queue write and then the output register load before it is valid.
//   A 4-entry queue parts the parser from the output register; o_ready drops
//   only when it is full, so a stalled receiver backs up into the queue and
//   then into the input channel without losing words.
//   Reset (synchronous, active low) clears parser state and the queue, sets
//   the separator to comma and normalization off. Configure via APB at byte
//   addresses 0 and 4 only while idle; the block does not enforce idle.
// ---------------------------------------------------------------------------
module csv_field_parser_normalizer_top import cfpn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_sep;
    logic       r_norm;
    logic       cfg_wr;
    t_reg       cfg_sel;

    logic   accept;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_valid;
    t_entry front_entry;
    t_entry q_entry;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep  <= SEP_RESET;
            r_norm <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_SEP:  r_sep  <= pwdata[7:0];
                REG_NORM: r_norm <= pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_SEP:  prdata = {24'h0, r_sep};
            REG_NORM: prdata = {31'h0, r_norm};
            default:  prdata = '0;
        endcase
    end

    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    cfpn_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_func    (i_func),
        .i_in_byte (i_in_byte),
        .i_sep     (r_sep),
        .i_norm    (r_norm),
        .o_push    (q_push),
        .o_entry   (front_entry)
    );

    cfpn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    cfpn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_entry),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_kind (o_out_kind),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule
